// ----- sv/hcd_pkg.sv -----
// Shared types and constants of the HUFF/CDIC symbol decoder.
// Used by huffcdic_symbol_decoder_core; no dependencies.
package hcd_pkg;

  localparam int unsigned WindowBits  = 32;
  localparam int unsigned CacheDepth  = 256;
  localparam int unsigned LenCount    = 32;
  localparam int unsigned TopShift    = 24;
  localparam int unsigned LenMask     = 'h1F;
  localparam int unsigned TermBit     = 7;

  localparam logic [1:0] ModeCacheWr = 2'd0;
  localparam logic [1:0] ModeBaseWr  = 2'd1;
  localparam logic [1:0] ModeDecode  = 2'd2;

  localparam logic [1:0] StDecoded   = 2'd0;
  localparam logic [1:0] StWritten   = 2'd1;
  localparam logic [1:0] StInvalid   = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  table_index;
    logic [31:0] table_word;
    logic [31:0] bit_window;
  } hcd_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  code_length;
    logic [31:0] dictionary_number;
    logic [31:0] entry_index;
  } hcd_rsp_t;

endpackage

// ----- sv/hcd_ram.sv -----
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
module hcd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/huffcdic_symbol_decoder_core.sv -----
// HUFF/CDIC Huffman symbol decoder: five-stage pipeline with cache RAM.
// Depends on hcd_pkg and hcd_ram.
//
// Usage:
//   in channel  (in_valid_i/in_ready_o/in_req_i): one request per item; mode
//     selects a cache-table write, a base-table write or a symbol decode.
//   out channel (out_valid_o/out_ready_i/out_rsp_o): one response per request,
//     in request order.
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i): writes entry_bits; it is
//     always ready and must only be written while no request is in flight.
// A request passes five register stages (cache read, length compare, length
//   select and base read, subtract, split), the last being the response
//   register. Throughput: one request per cycle unless the receiver stalls.
// When the receiver stalls the whole pipeline freezes; in_ready_o drops while
//   a response waits in the output register and the receiver is not ready.
// Reset clears all stage valid bits and entry_bits. The cache and base tables
//   are not cleared and hold undefined data until written.
module huffcdic_symbol_decoder_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hcd_pkg::hcd_req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hcd_pkg::hcd_rsp_t out_rsp_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [4:0]      cfg_data_i
);
  import hcd_pkg::*;

  logic        adv;
  logic [4:0]  entry_bits_q;

  // base table: min code per length and symbol base per length
  logic [31:0] min_q  [LenCount];
  logic [31:0] base_q [LenCount];

  // stage 1
  logic        s1_valid_q;
  hcd_req_t    s1_req_q;
  logic [31:0] cache_rdata;
  logic [4:0]  s1_len0;
  logic [31:0] s1_hit;

  // stage 2
  logic        s2_valid_q;
  logic [1:0]  s2_mode_q;
  logic [7:0]  s2_idx_q;
  logic [31:0] s2_word_q;
  logic [31:0] s2_window_q;
  logic [4:0]  s2_len0_q;
  logic        s2_term_q;
  logic [23:0] s2_tbase_q;
  logic [31:0] s2_hit_q;
  logic [4:0]  s2_lf;
  logic [5:0]  s2_len;
  logic [1:0]  s2_status;

  // stage 3
  logic        s3_valid_q;
  logic [1:0]  s3_status_q;
  logic [5:0]  s3_len_q;
  logic [31:0] s3_code_q;
  logic [31:0] s3_base_q;

  // stage 4
  logic        s4_valid_q;
  logic [1:0]  s4_status_q;
  logic [5:0]  s4_len_q;
  logic [31:0] s4_sym_q;

  // output
  logic        out_valid_q;
  hcd_rsp_t    out_rsp_q;
  hcd_rsp_t    out_rsp_d;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_bits_q <= '0;
    end else if (cfg_valid_i) begin
      entry_bits_q <= cfg_data_i;
    end
  end

  hcd_ram #(
    .Width(32),
    .Depth(CacheDepth)
  ) u_cache (
    .clk_i  (clk_i),
    .we_i   (in_valid_i && adv && in_req_i.mode == ModeCacheWr),
    .waddr_i(in_req_i.table_index),
    .wdata_i(in_req_i.table_word),
    .re_i   (in_valid_i && adv),
    .raddr_i(in_req_i.bit_window[TopShift +: 8]),
    .rdata_o(cache_rdata)
  );

  // stage 1: compare every candidate length against its minimum
  assign s1_len0 = cache_rdata[4:0] & 5'(LenMask);

  always_comb begin
    for (int l = 0; l < LenCount; l++) begin
      s1_hit[l] = ((s1_req_q.bit_window >> (WindowBits - 32'(l) - 1)) >= min_q[l]) &&
                  ((6'(l) + 6'd1) >= {1'b0, s1_len0});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q && s1_req_q.mode == ModeBaseWr &&
        s1_req_q.table_index[7:6] == 2'b00 && !s1_req_q.table_index[0]) begin
      min_q[s1_req_q.table_index[5:1]] <= s1_req_q.table_word;
    end
    if (adv && s2_valid_q && s2_mode_q == ModeBaseWr &&
        s2_idx_q[7:6] == 2'b00 && s2_idx_q[0]) begin
      base_q[s2_idx_q[5:1]] <= s2_word_q;
    end
  end

  // stage 2: pick the final length, read its base, extract the code
  always_comb begin
    s2_lf = '0;
    for (int l = LenCount - 1; l >= 0; l--) begin
      if (s2_hit_q[l]) begin
        s2_lf = 5'(l);
      end
    end
  end

  assign s2_len = s2_term_q ? {1'b0, s2_len0_q} : ({1'b0, s2_lf} + 6'd1);

  always_comb begin
    priority if (s2_mode_q == ModeCacheWr || s2_mode_q == ModeBaseWr) begin
      s2_status = StWritten;
    end else if (s2_mode_q != ModeDecode) begin
      s2_status = StInvalid;
    end else if (s2_len0_q == 5'd0 || (!s2_term_q && s2_hit_q == '0)) begin
      s2_status = StInvalid;
    end else begin
      s2_status = StDecoded;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_req_q    <= in_req_i;
      s2_mode_q   <= s1_req_q.mode;
      s2_idx_q    <= s1_req_q.table_index;
      s2_word_q   <= s1_req_q.table_word;
      s2_window_q <= s1_req_q.bit_window;
      s2_len0_q   <= s1_len0;
      s2_term_q   <= cache_rdata[TermBit];
      s2_tbase_q  <= cache_rdata[31:8];
      s2_hit_q    <= s1_hit;
      s3_status_q <= s2_status;
      s3_len_q    <= (s2_status == StDecoded) ? s2_len : 6'd0;
      s3_code_q   <= s2_window_q >> (6'd32 - s2_len);
      s3_base_q   <= s2_term_q ? {8'd0, s2_tbase_q} : base_q[s2_lf];
      s4_status_q <= s3_status_q;
      s4_len_q    <= s3_len_q;
      s4_sym_q    <= s3_base_q - s3_code_q;
      out_rsp_q   <= out_rsp_d;
    end
  end

  // stage 4: split the symbol value
  always_comb begin
    out_rsp_d.status            = s4_status_q;
    out_rsp_d.code_length       = s4_len_q;
    out_rsp_d.dictionary_number = '0;
    out_rsp_d.entry_index       = '0;
    if (s4_status_q == StDecoded) begin
      out_rsp_d.dictionary_number = s4_sym_q >> entry_bits_q;
      out_rsp_d.entry_index       = s4_sym_q & ((32'd1 << entry_bits_q) - 32'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
